// ===== rtl/core/wnm_pkg.sv =====
// ============================================================================
// wnm_pkg: shared types and constants of the wildcard name matcher
// Action codes, wildcard byte values, result word and per-cell control word.
// ============================================================================
`default_nettype none

package wnm_pkg;

    localparam int PATTERN_DEPTH_DEF = 32;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_NAME   = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic       restart;  // clear or end of name: back to position zero
        logic       feed;     // name byte step
        logic       wr;       // pattern byte write at position len
        logic [7:0] chr;      // pattern or name byte
        logic       absorb;   // absorbed mark for the byte being written
        logic       glob;     // wildcards enabled
    } t_cell_ctl;

    typedef struct packed {
        logic match;
        logic ovf;
    } t_result;

endpackage : wnm_pkg

`default_nettype wire

// ===== rtl/core/wildcard_name_matcher_unit.sv =====
// ============================================================================
// wildcard_name_matcher_unit: glob-style name matcher against a stored pattern
// Cell chain, one active bit each; one input word per cycle unless stalled.
// ============================================================================
// Usage:
//  - Input stream (i_s_*): one word per byte. tuser carries the action
//    (clear pattern, append pattern byte, name byte, end of name), tdata the
//    byte. Words may arrive back to back.
//  - Output stream (o_m_*): one word per end-of-name action. tdata[0] is the
//    match bit, tuser[0] the pattern overflow flag (match is then 0).
//    The result is registered, in the skid entry while another one waits.
//  - APB port: register 0 (address 0), bit 0 = glob_enable, reset 1. Write
//    only while no result is pending; pready is tied high.
//  - Throughput: one word per cycle unless stalled. A name byte updates every
//    active position at once; the star/absorbed skip closure ripples through
//    the cell chain inside that cycle, so chain length sets the clock limit.
//  - Stall: results sit in an output register plus a skid entry. The input
//    keeps flowing while one result waits; o_s_tready drops only while both
//    entries are full, and rises again the cycle after the receiver takes one.
//  - Reset (synchronous, active low): empty pattern, only position zero
//    active, overflow clear, glob mode on, output buffer empty. No clearing
//    pass: pattern bytes at or beyond the pattern length are never read.
// ============================================================================
`default_nettype none

module wildcard_name_matcher_unit
    import wnm_pkg::*;
#(
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] character
    input  wire logic [1:0]  i_s_tuser,   // [1:0] action
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [0] match, [7:1] zero
    output logic [0:0]       o_m_tuser,   // [0] pattern_overflow
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LENW = $clog2(PATTERN_DEPTH + 1);
    localparam logic [LENW-1:0] FULL_LEN = LENW'(PATTERN_DEPTH);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic r_glob;
    logic cfg_wr;
    logic cfg_sel0;

    assign pready   = 1'b1;
    assign cfg_sel0 = (paddr[2] == 1'b0);
    assign cfg_wr   = psel & penable & pwrite & pready & cfg_sel0;
    assign prdata   = cfg_sel0 ? {31'd0, r_glob} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glob <= 1'b1;
        end else if (cfg_wr) begin
            r_glob <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // input decode and pattern bookkeeping
    // ------------------------------------------------------------------
    t_action   act;
    logic      accept;
    logic      full;
    logic      buf_full;
    t_cell_ctl ctl;

    logic [LENW-1:0] r_len;
    logic [LENW-1:0] n_len;
    logic            r_star_run;
    logic            n_star_run;
    logic            r_ovf;
    logic            n_ovf;
    logic            absorb;

    assign act        = t_action'(i_s_tuser);
    assign o_s_tready = !buf_full;
    assign accept     = i_s_tvalid & o_s_tready;
    assign full       = (r_len == FULL_LEN);

    always_comb begin
        n_len      = r_len;
        n_star_run = r_star_run;
        n_ovf      = r_ovf;
        absorb     = 1'b0;
        if (accept) begin
            unique case (act)
                ACT_CLEAR: begin
                    n_len      = '0;
                    n_star_run = 1'b0;
                    n_ovf      = 1'b0;
                end
                ACT_APPEND: begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LENW'(1);
                        priority if (i_s_tdata == STAR_BYTE) begin
                            n_star_run = 1'b1;
                        end else if (i_s_tdata == QMARK_BYTE) begin
                            absorb = r_star_run;  // '?' inside a star run
                        end else begin
                            n_star_run = 1'b0;
                        end
                    end
                end
                ACT_NAME, ACT_END: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_star_run <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_star_run <= n_star_run;
            r_ovf      <= n_ovf;
        end
    end

    assign ctl.restart = accept & ((act == ACT_CLEAR) | (act == ACT_END));
    assign ctl.feed    = accept & (act == ACT_NAME);
    assign ctl.wr      = accept & (act == ACT_APPEND) & !full;
    assign ctl.chr     = i_s_tdata;
    assign ctl.absorb  = absorb;
    assign ctl.glob    = r_glob;

    // ------------------------------------------------------------------
    // cell chain: positions 0..PATTERN_DEPTH
    // ------------------------------------------------------------------
    logic [PATTERN_DEPTH+1:0] carry;
    logic [PATTERN_DEPTH+1:0] shift;
    logic [PATTERN_DEPTH:0]   hit_vec;

    assign carry[0] = 1'b0;
    assign shift[0] = 1'b0;

    for (genvar g = 0; g <= PATTERN_DEPTH; g++) begin : g_cell
        wnm_cell #(
            .DEPTH (PATTERN_DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_len   (r_len),
            .i_carry (carry[g]),
            .i_shift (shift[g]),
            .o_carry (carry[g+1]),
            .o_shift (shift[g+1]),
            .o_hit   (hit_vec[g])
        );
    end

    // the last position never holds a byte, so nothing leaves the chain end
    logic chain_end_unused;
    assign chain_end_unused = carry[PATTERN_DEPTH+1] | shift[PATTERN_DEPTH+1];

    // ------------------------------------------------------------------
    // result
    // ------------------------------------------------------------------
    t_result res_in;
    t_result res_out;
    logic    push;

    assign push         = accept & (act == ACT_END);
    assign res_in.match = (|hit_vec) & !r_ovf & !chain_end_unused;
    assign res_in.ovf   = r_ovf;

    wnm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res_in),
        .i_ready (i_m_tready),
        .o_full  (buf_full),
        .o_valid (o_m_tvalid),
        .o_res   (res_out)
    );

    assign o_m_tdata = {7'd0, res_out.match};
    assign o_m_tuser = res_out.ovf;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= FULL_LEN)
        else $error("pattern length beyond depth");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flag set with room left");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && act == ACT_CLEAR) |=> (r_len == '0 && !r_ovf && !r_star_run))
        else $error("clear did not empty the pattern");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_m_tvalid)
        else $error("end of name produced no result word");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> !o_m_tdata[0])
        else $error("match reported with overflowed pattern");

endmodule : wildcard_name_matcher_unit

`default_nettype wire

// ===== rtl/core/wnm_cell.sv =====
// ============================================================================
// wnm_cell: one pattern position of the matcher chain
// Holds a pattern byte, its absorbed mark and the active bit of the position;
// passes the free-skip closure and the advance bit to the next cell.
// ============================================================================
`default_nettype none

module wnm_cell
    import wnm_pkg::*;
#(
    parameter int DEPTH = PATTERN_DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cell_ctl                  i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_len,
    input  wire logic                       i_carry,  // closure from left neighbor
    input  wire logic                       i_shift,  // advance from left neighbor
    output logic                            o_carry,
    output logic                            o_shift,
    output logic                            o_hit     // closed and at pattern end
);

    localparam int LENW = $clog2(DEPTH + 1);
    localparam logic [LENW-1:0] MY_POS = LENW'(INDEX);
    localparam logic RST_ACT = (INDEX == 0);

    logic [7:0] r_byte;
    logic       r_abs;
    logic       r_act;
    logic       n_act;

    logic valid;
    logic is_star;
    logic is_q;
    logic same;
    logic closed;
    logic stay;

    assign valid   = (i_len > MY_POS);
    assign is_star = (r_byte == STAR_BYTE);
    assign is_q    = (r_byte == QMARK_BYTE);
    assign same    = (r_byte == i_ctl.chr);
    assign closed  = r_act | i_carry;

    assign o_carry = closed & valid & i_ctl.glob & (is_star | r_abs);
    assign stay    = closed & valid & i_ctl.glob & is_star;
    assign o_shift = closed & valid &
                     (i_ctl.glob ? (!is_star && !r_abs && (is_q || same)) : same);
    assign o_hit   = closed & (i_len == MY_POS);

    always_comb begin
        if (i_ctl.restart) begin
            n_act = RST_ACT;
        end else if (i_ctl.feed) begin
            n_act = stay | i_shift;
        end else begin
            n_act = r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= RST_ACT;
        end else begin
            r_act <= n_act;
        end
    end

    // pattern store: no reset, only entries below len are ever used
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_len == MY_POS)) begin
            r_byte <= i_ctl.chr;
            r_abs  <= i_ctl.absorb;
        end
    end

endmodule : wnm_cell

`default_nettype wire

// ===== rtl/core/wnm_out_buf.sv =====
// ============================================================================
// wnm_out_buf: result output register with skid stage
// Two-entry buffer between the matcher and the result stream; ready toward
// the input side is registered (low only while the skid entry is held).
// ============================================================================
`default_nettype none

module wnm_out_buf
    import wnm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_full,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid & i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |=> (r_skid_valid && $stable(r_skid)))
        else $error("held skid word lost or changed");

    a_stalled_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result word changed");

endmodule : wnm_out_buf

`default_nettype wire

// ===== bench/tb_wildcard_name_matcher_unit.sv =====
// ============================================================================
// tb_wildcard_name_matcher_unit: self-checking bench of the wildcard matcher
// Feeds pattern and name words through the input stream, predicts each
// end-of-name verdict with an independent bit-set model, and compares every
// result word field by field under random idling and receiver back-pressure.
// ============================================================================

module tb_wildcard_name_matcher_unit
    import wnm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH         = PATTERN_DEPTH_DEF;
    localparam logic [2:0]  GLOB_REG_ADDR = 3'd0;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          WORDS_PER_PHASE = 150;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;     // [7:0] character
    logic [1:0]  i_s_tuser  = '0;     // [1:0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;           // [0] match, [7:1] zero
    logic [0:0]  o_m_tuser;           // [0] pattern_overflow
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    wildcard_name_matcher_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Matcher model: pattern store, star-run tracking, active position set
    // ------------------------------------------------------------------
    logic [7:0]     pat_byte   [DEPTH];
    logic           pat_absorb [DEPTH];
    int             pat_len    = 0;
    logic           star_run   = 1'b0;
    logic           pat_ovf    = 1'b0;
    logic [DEPTH:0] active_pos = (DEPTH+1)'(1);
    logic           glob_on    = 1'b1;   // reset value of the register

    t_result        verdict_q[$];        // verdicts still owed by the block

    // run statistics and error tally
    int errors        = 0;
    int words_sent    = 0;
    int verdicts_seen = 0;
    int match_seen    = 0;
    int ovf_seen      = 0;
    int input_stalls  = 0;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: request toggles, receiver counts it down
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;

    // Positions reachable without eating a name byte: a star, or a '?' that
    // was swallowed by a preceding star run, can be stepped over for free.
    // The loop runs upward so skips chain through several wildcards.
    function automatic logic [DEPTH:0] close_positions(logic [DEPTH:0] act);
        logic [DEPTH:0] c;
        int i;
        c = act;
        for (i = 0; i < pat_len; i++)
            if (c[i] && glob_on && (pat_byte[i] == STAR_BYTE || pat_absorb[i]))
                c[i+1] = 1'b1;
        return c;
    endfunction

    task automatic predict_word(t_action act, logic [7:0] chr);
        logic [DEPTH:0] cur;
        logic [DEPTH:0] nxt;
        t_result        r;
        int             i;
        case (act)
            ACT_CLEAR: begin
                pat_len    = 0;
                star_run   = 1'b0;
                pat_ovf    = 1'b0;
                active_pos = (DEPTH+1)'(1);
            end
            ACT_APPEND: begin
                if (pat_len >= DEPTH) begin
                    pat_ovf = 1'b1;     // byte dropped, store untouched
                end else begin
                    pat_absorb[pat_len] = (chr == QMARK_BYTE) && star_run;
                    if (chr == STAR_BYTE)
                        star_run = 1'b1;
                    else if (chr != QMARK_BYTE)
                        star_run = 1'b0;
                    pat_byte[pat_len] = chr;
                    pat_len++;
                end
            end
            ACT_NAME: begin
                cur = close_positions(active_pos);
                nxt = '0;
                for (i = 0; i < pat_len; i++) begin
                    if (cur[i]) begin
                        if (glob_on) begin
                            if (pat_byte[i] == STAR_BYTE)
                                nxt[i] = 1'b1;
                            else if (!pat_absorb[i] &&
                                     (pat_byte[i] == QMARK_BYTE || pat_byte[i] == chr))
                                nxt[i+1] = 1'b1;
                        end else if (pat_byte[i] == chr) begin
                            nxt[i+1] = 1'b1;
                        end
                    end
                end
                active_pos = nxt;
            end
            default: begin
                cur     = close_positions(active_pos);
                r.match = cur[pat_len] && !pat_ovf;
                r.ovf   = pat_ovf;
                verdict_q.push_back(r);
                active_pos = (DEPTH+1)'(1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side: one word per call, held until the handshake completes.
    // tvalid stays high between back-to-back words; it is lowered only when
    // an idle gap is inserted or when the bench waits for quiet.
    // ------------------------------------------------------------------
    task automatic send_word(t_action act, logic [7:0] chr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= chr;
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        predict_word(act, chr);
        words_sent++;
    endtask

    // Stop offering words and let every owed verdict come out, then idle on
    // for a word that produces no result.
    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup, access, register taken when pready is high
    task automatic write_glob(logic value);
        wait_quiet();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= GLOB_REG_ADDR;
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        glob_on = value;
    endtask

    task automatic send_string(t_action act, string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(act, s[i]);
    endtask

    // byte mix that favors a small alphabet so names actually hit patterns
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0, 1:    return "a";
            2, 3:    return "b";
            4:       return "c";
            5:       return STAR_BYTE;
            6:       return QMARK_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: checks each verdict word, drives tready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                verdicts_seen++;
                match_seen += o_m_tdata[0];
                ovf_seen   += o_m_tuser[0];
                if (verdict_q.size() == 0) begin
                    $error("result word with no verdict pending: match %0b overflow %0b",
                           o_m_tdata[0], o_m_tuser[0]);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_m_tdata[0] !== want.match) begin
                        $error("match: expected %0b, got %0b", want.match, o_m_tdata[0]);
                        errors++;
                    end
                    if (o_m_tuser[0] !== want.ovf) begin
                        $error("pattern_overflow: expected %0b, got %0b",
                               want.ovf, o_m_tuser[0]);
                        errors++;
                    end
                end
            end
            // hold-off request wins over random stalls
            if (hold_req != hold_ack) begin
                hold_ack   <= hold_req;
                hold_left  <= HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without a word moving on either side ends the run
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_s_tvalid && !o_s_tready)
            input_stalls++;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
            $display("** wildcard_name_matcher_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty pattern, zero bytes, absorbed '?', plain '?', clear mid-name,
    // append mid-name, 0xFF bytes, ignored characters on clear/end.
    task automatic test_directed();
        send_word(ACT_END, 8'hFF);              // empty pattern, empty name
        send_word(ACT_APPEND, 8'h00);
        send_word(ACT_NAME, 8'h00);
        send_word(ACT_END, 8'h00);              // zero byte is a literal
        send_word(ACT_CLEAR, 8'hFF);
        send_string(ACT_APPEND, "*?a");         // '?' swallowed by the star run
        send_word(ACT_NAME, "a");
        send_word(ACT_END, 8'h00);
        send_word(ACT_APPEND, QMARK_BYTE);      // after 'a': a real one-byte wildcard
        send_string(ACT_NAME, "za");
        send_word(ACT_NAME, 8'hFF);
        send_word(ACT_END, 8'h00);
        send_word(ACT_NAME, "a");
        send_word(ACT_CLEAR, 8'h00);            // restarts the name too
        send_word(ACT_APPEND, 8'hFF);
        send_word(ACT_NAME, 8'hFF);
        send_word(ACT_APPEND, "b");             // pattern grows under a live name
        send_word(ACT_NAME, "b");
        send_word(ACT_END, 8'h00);
        send_word(ACT_NAME, 8'hFE);
        send_word(ACT_END, 8'h00);              // mismatch
        wait_quiet();
    endtask

    // Exactly full pattern matches; one byte more sets overflow and kills match
    task automatic test_overflow();
        logic [7:0] fill[$];
        int i;
        for (i = 0; i < DEPTH; i++)
            fill.push_back(8'($urandom_range(64, 90)));
        send_word(ACT_CLEAR, 8'h00);
        foreach (fill[i]) send_word(ACT_APPEND, fill[i]);
        foreach (fill[i]) send_word(ACT_NAME, fill[i]);
        send_word(ACT_END, 8'h00);
        send_word(ACT_APPEND, STAR_BYTE);       // dropped
        foreach (fill[i]) send_word(ACT_NAME, fill[i]);
        send_word(ACT_END, 8'h00);
        send_word(ACT_END, 8'h00);              // flag sticks until clear
        send_word(ACT_CLEAR, 8'h00);
        send_word(ACT_END, 8'h00);
        wait_quiet();
    endtask

    // Exact mode: wildcards are literals; mode switch while a name is open
    task automatic test_exact_mode();
        write_glob(1'b0);
        send_word(ACT_CLEAR, 8'h00);
        send_string(ACT_APPEND, "*?b");
        send_string(ACT_NAME, "*?b");
        send_word(ACT_END, 8'h00);
        send_string(ACT_NAME, "xyb");
        send_word(ACT_END, 8'h00);
        write_glob(1'b1);
        send_word(ACT_NAME, "a");               // name left open across the switch
        write_glob(1'b0);
        send_string(ACT_NAME, "?b");
        send_word(ACT_END, 8'h00);
        wait_quiet();
        write_glob(1'b1);
    endtask

    // One random block: optional noise, a fresh pattern, a few names built
    // from it (sometimes corrupted), each closed by end of name.
    task automatic run_pattern_block();
        logic [7:0] pat[$];
        logic [7:0] name[$];
        int plen;
        int i;
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 4))
                send_word(t_action'($urandom_range(3)), 8'($urandom_range(255)));
        send_word(ACT_CLEAR, 8'($urandom_range(255)));
        plen = ($urandom_range(19) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 2)
                                         : $urandom_range(0, 6);
        for (i = 0; i < plen; i++) begin
            pat.push_back(pick_byte());
            send_word(ACT_APPEND, pat[i]);
        end
        repeat ($urandom_range(1, 3)) begin
            name.delete();
            foreach (pat[i]) begin
                if (pat[i] == STAR_BYTE)
                    repeat ($urandom_range(0, 2)) name.push_back(pick_byte());
                else if (pat[i] == QMARK_BYTE)
                    name.push_back(8'($urandom_range(255)));
                else
                    name.push_back(pat[i]);
            end
            if (name.size() != 0 && $urandom_range(3) == 0)
                name[$urandom_range(name.size() - 1)] = pick_byte();
            foreach (name[i]) send_word(ACT_NAME, name[i]);
            send_word(ACT_END, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, logic glob);
        int target;
        write_glob(glob);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = words_sent + WORDS_PER_PHASE;
        while (words_sent < target)
            run_pattern_block();
        wait_quiet();
    endtask

    // Receiver holds off while a burst of verdicts is offered: the result
    // buffer fills and the input side must stall until the hold ends.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= ~hold_req;
        send_word(ACT_CLEAR, 8'h00);
        send_word(ACT_APPEND, STAR_BYTE);
        repeat (16) begin
            send_word(ACT_NAME, 8'($urandom_range(255)));
            send_word(ACT_END, 8'h00);
        end
        wait_quiet();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_exact_mode();
        test_random_phase(0, 0, 1'b1);
        test_random_phase(53, 0, 1'b0);
        test_random_phase(0, 53, 1'b1);
        test_random_phase(17, 17, 1'b0);
        test_backpressure();

        wait_quiet();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d input words and %0d verdicts (%0d matches, %0d overflow),",
                 words_sent, verdicts_seen, match_seen, ovf_seen);
        $display("both glob modes, four idling mixes and %0d stalled input cycles.",
                 input_stalls);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("** wildcard_name_matcher_unit: PASSED **");
        end else begin
            $display("** wildcard_name_matcher_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== wildcard_name_matcher_unit.f =====
rtl/core/wnm_pkg.sv
rtl/core/wnm_cell.sv
rtl/core/wnm_out_buf.sv
rtl/core/wildcard_name_matcher_unit.sv
bench/tb_wildcard_name_matcher_unit.sv
